[rtl/assert_macros.svh]
// Assertion helpers for the index converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define MRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked during reset as well.
`define MRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRC_ASSERT(label, prop, msg)
`define MRC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[rtl/mrc_pkg.sv]
package mrc_pkg;

  localparam int MAX_DIGITS  = 4;
  localparam int NUM_DIGITS  = 4;
  localparam int STEPS_PER_D = 4;
  localparam int BITS_PER_ST = 32 / STEPS_PER_D;
  localparam int NUM_STAGES  = NUM_DIGITS * STEPS_PER_D;
  localparam int SLOT_W      = 2;

  localparam logic OP_SPLIT   = 1'b0;
  localparam logic OP_COMBINE = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic                        valid;
    logic                        op;
    logic [31:0]                 idx;
    logic [MAX_DIGITS-1:0][7:0]  din;
    logic [31:0]                 w;
    logic [7:0]                  rem;
    logic [MAX_DIGITS-1:0][7:0]  dout;
    logic                        flag;
  } stage_t;

  // Per-stage control, fixed at elaboration.
  typedef struct packed {
    logic  first;
    logic  last;
    logic  mul_en;
    slot_t sdig;
    slot_t cdig;
    logic  final_grp;
  } stage_ctl_t;

  function automatic logic [7:0] eff_radix(input logic [7:0] r);
    eff_radix = (r == 8'd0) ? 8'd1 : r;
  endfunction

endpackage

[rtl/mrc_div_stage.sv]
module mrc_div_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ce,
  input  mrc_pkg::stage_ctl_t ctl,
  input  logic [7:0]         div,
  input  logic [7:0]         mul_radix,
  input  mrc_pkg::stage_t    s_i,
  output mrc_pkg::stage_t    s_o
);

  logic            valid_r;
  mrc_pkg::stage_t pay_r;
  mrc_pkg::stage_t pay_nxt;

  always_comb begin
    logic [31:0] w;
    logic [7:0]  rem;
    logic [8:0]  r9;
    logic [39:0] prod;
    pay_nxt = s_i;
    w       = s_i.w;
    rem     = ctl.first ? 8'd0 : s_i.rem;
    r9      = 9'd0;
    prod    = 40'd0;
    if (s_i.op == mrc_pkg::OP_SPLIT) begin
      // restoring long division, a byte of quotient per stage
      for (int b = 0; b < mrc_pkg::BITS_PER_ST; b++) begin
        r9 = {rem, w[31]};
        w  = {w[30:0], 1'b0};
        if (r9 >= {1'b0, div}) begin
          r9   = r9 - {1'b0, div};
          w[0] = 1'b1;
        end
        rem = r9[7:0];
      end
      pay_nxt.w   = w;
      pay_nxt.rem = rem;
      if (ctl.last) begin
        pay_nxt.dout[ctl.sdig] = rem;
        if (ctl.final_grp) pay_nxt.flag = (w != 32'd0);
      end
    end else if (ctl.first && ctl.mul_en) begin
      // Horner step: acc * radix + next digit
      prod      = s_i.w * mul_radix;
      pay_nxt.w = prod[31:0] + {24'd0, s_i.din[ctl.cdig]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= s_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) pay_r <= pay_nxt;
  end

  always_comb begin
    s_o       = pay_r;
    s_o.valid = valid_r;
  end

endmodule

[rtl/mixed_radix_index_convert_top.sv]
// Mixed-radix index converter.
// Input beats: in_tuser selects the operation (0 split index into digits,
// 1 combine digits into index); in_tdata carries index and digits.
// Output beats: in_tdata-order fields plus an out_of_range flag.
// Split echoes the index; combine echoes the digits.
// Throughput: one beat per cycle while the receiver keeps out_tready high.
// The work runs through
// sixteen register stages: four per digit, each stage resolving eight
// quotient bits of a radix division by restoring compare and subtract.
// Combine uses one 32x8 multiply-add per digit after the first, in the
// first stage of that digit's group.
// Radices are written through cfg_we/cfg_addr/cfg_wdata; reset sets all to 2,
// and a radix of 0 behaves as 1. Write them only while the pipe is empty.
// Reset empties the pipe; no clearing pass is needed.
// When out_tready is low with a beat waiting, the whole pipe holds and
// in_tready drops; nothing is lost or repeated.
module mixed_radix_index_convert_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] index, [39:32] digit_in_0, [47:40] digit_in_1,
  // [55:48] digit_in_2, [63:56] digit_in_3
  input  logic [63:0] in_tdata,
  // [0] operation
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] index_out, [39:32] digit_out_0, [47:40] digit_out_1,
  // [55:48] digit_out_2, [63:56] digit_out_3, [64] out_of_range, [71:65] zero
  output logic [71:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  `include "assert_macros.svh"

  localparam int NS = mrc_pkg::NUM_STAGES;
  localparam int ND = mrc_pkg::NUM_DIGITS;

  logic [mrc_pkg::MAX_DIGITS-1:0][7:0] radix_r;
  logic [mrc_pkg::MAX_DIGITS-1:0][7:0] eff;
  mrc_pkg::stage_t                     s [NS+1];
  logic                                ce;
  logic                                cmb_flag;
  logic                                split_chk;
  logic                                split_dig_ok;
  logic                                out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mrc_pkg::MAX_DIGITS; i++) radix_r[i] <= 8'd2;
    end else if (cfg_we) begin
      radix_r[cfg_addr] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < mrc_pkg::MAX_DIGITS; i++) eff[i] = mrc_pkg::eff_radix(radix_r[i]);
  end

  assign ce        = !s[NS].valid || out_tready;
  assign in_tready = ce;

  always_comb begin
    cmb_flag = 1'b0;
    for (int i = 0; i < ND; i++) begin
      if (in_tdata[32+8*i +: 8] >= eff[i]) cmb_flag = 1'b1;
    end
  end

  always_comb begin
    s[0].valid = in_tvalid;
    s[0].op    = in_tuser;
    s[0].idx   = in_tdata[31:0];
    s[0].din   = '0;
    for (int i = 0; i < ND; i++) s[0].din[i] = in_tdata[32+8*i +: 8];
    s[0].rem   = 8'd0;
    if (in_tuser == mrc_pkg::OP_COMBINE) begin
      s[0].w    = {24'd0, in_tdata[39:32]};
      s[0].dout = s[0].din;
      s[0].flag = cmb_flag;
    end else begin
      s[0].w    = in_tdata[31:0];
      s[0].dout = '0;
      s[0].flag = 1'b0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int G    = k / mrc_pkg::STEPS_PER_D;
    localparam int STEP = k % mrc_pkg::STEPS_PER_D;
    mrc_pkg::stage_ctl_t ctl;
    assign ctl.first     = (STEP == 0);
    assign ctl.last      = (STEP == mrc_pkg::STEPS_PER_D - 1);
    assign ctl.mul_en    = (G != 0);
    assign ctl.sdig      = mrc_pkg::SLOT_W'(ND - 1 - G);
    assign ctl.cdig      = mrc_pkg::SLOT_W'(G);
    assign ctl.final_grp = (G == ND - 1);
    mrc_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .ce        (ce),
      .ctl       (ctl),
      .div       (eff[ND-1-G]),
      .mul_radix (eff[G]),
      .s_i       (s[k]),
      .s_o       (s[k+1])
    );
  end

  assign out_tvalid       = s[NS].valid;
  assign out_tdata[31:0]  = (s[NS].op == mrc_pkg::OP_COMBINE) ? s[NS].w : s[NS].idx;
  assign out_tdata[63:32] = s[NS].dout;
  assign out_tdata[64]    = s[NS].flag;
  assign out_tdata[71:65] = 7'd0;

  assign split_chk    = out_tvalid && (s[NS].op == mrc_pkg::OP_SPLIT);
  assign split_dig_ok = (out_tdata[39:32] != 8'hFF) && (out_tdata[47:40] != 8'hFF) &&
                        (out_tdata[55:48] != 8'hFF) && (out_tdata[63:56] != 8'hFF);
  assign out_stall    = out_tvalid && !out_tready;

  // hold the output beat while the receiver stalls
  `MRC_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata), "beat changed in stall")
  // a remainder never reaches 255, so split digits cannot be all ones
  `MRC_ASSERT(a_split_digits, split_chk |-> split_dig_ok, "split digit out of radix bound")
  // reset empties the pipe
  `MRC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

[tb/sv/tb_mixed_radix_index_convert_top.sv]
`timescale 1ns / 1ps

module tb_mixed_radix_index_convert_top;

  typedef struct packed {
    logic        op;
    logic [31:0] idx;
    logic [3:0][7:0] dig;
  } conv_req_t;

  typedef struct packed {
    logic [31:0] idx;
    logic [3:0][7:0] dig;
    logic        oor;
  } conv_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [7:0]  cfg_wdata;

  mixed_radix_index_convert_top dut (.*);

  logic [7:0] radix_q [4];
  conv_req_t  req_q [$];
  conv_res_t  expected_q [$];
  int         errors = 0;
  int         cycle = 0;
  int         send_wait;
  int         recv_wait;
  int         hold_cycles = 0;
  bit         hold_req = 0;
  bit         hold_done = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle <= cycle + 1;

  function automatic conv_res_t predict_conversion(conv_req_t r);
    conv_res_t res;
    logic [63:0] wt [4];
    logic [63:0] rad [4];
    logic [63:0] total;
    logic [63:0] sum;
    res = '0;
    for (int i = 0; i < 4; i++) rad[i] = (radix_q[i] == 0) ? 64'd1 : 64'(radix_q[i]);
    wt[mrc_pkg::NUM_DIGITS-1] = 1;
    for (int i = mrc_pkg::NUM_DIGITS - 2; i >= 0; i--) wt[i] = wt[i+1] * rad[i+1];
    total = wt[0] * rad[0];
    if (r.op == mrc_pkg::OP_SPLIT) begin
      for (int i = 0; i < mrc_pkg::NUM_DIGITS; i++)
        res.dig[i] = 8'((64'(r.idx) / wt[i]) % rad[i]);
      res.oor = 64'(r.idx) >= total;
      res.idx = r.idx;
    end else begin
      sum = 0;
      for (int i = 0; i < mrc_pkg::NUM_DIGITS; i++) begin
        res.dig[i] = r.dig[i];
        if (64'(r.dig[i]) >= rad[i]) res.oor = 1;
        sum += 64'(r.dig[i]) * wt[i];
      end
      res.idx = sum[31:0];
    end
    return res;
  endfunction

  // driver: one beat per pending item, random gap after each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tuser  <= 0;
      in_tdata  <= '0;
      send_wait <= 0;
    end else if (in_tvalid && !in_tready) begin
      // hold the beat
    end else if (send_wait > 0) begin
      in_tvalid <= 0;
      send_wait <= send_wait - 1;
    end else if (req_q.size() > 0) begin
      conv_req_t r;
      r = req_q.pop_front();
      in_tvalid <= 1;
      in_tuser  <= r.op;
      in_tdata  <= {r.dig, r.idx};
      expected_q = {expected_q, predict_conversion(r)};
      send_wait <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
    end else begin
      in_tvalid <= 0;
    end
  end

  // monitor: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      recv_wait  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        conv_res_t got, exp;
        got = {out_tdata[31:0], out_tdata[63:32], out_tdata[64]};
        if (expected_q.size() == 0) begin
          $error("unexpected beat %h", out_tdata);
          errors++;
        end else begin
          exp = expected_q.pop_front();
          if (got.idx !== exp.idx) begin
            $error("index_out exp %h got %h", exp.idx, got.idx); errors++;
          end
          for (int i = 0; i < 4; i++)
            if (got.dig[i] !== exp.dig[i]) begin
              $error("digit_out_%0d exp %h got %h", i, exp.dig[i], got.dig[i]);
              errors++;
            end
          if (got.oor !== exp.oor) begin
            $error("out_of_range exp %b got %b", exp.oor, got.oor); errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        out_tready  <= 0;
        hold_cycles <= 300;
        hold_done   <= 1;
      end else if (hold_cycles > 0) begin
        out_tready <= 0;
        hold_cycles <= hold_cycles - 1;
      end else if (recv_wait > 0) begin
        out_tready <= 0;
        recv_wait <= recv_wait - 1;
      end else begin
        out_tready <= 1;
        if (out_tvalid && out_tready)
          recv_wait <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
      end
    end
  end

  always @(posedge clk)
    if (cycle > 400000) begin
      $display("tb_mixed_radix_index_convert_top: done, errors");
      $finish;
    end

  task automatic write_radix(input logic [1:0] a, input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_addr <= a; cfg_wdata <= v;
    radix_q[a] = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic queue_req(input conv_req_t r);
    req_q = {req_q, r};
  endtask

  task automatic drain_pipe();
    while (req_q.size() > 0 || expected_q.size() > 0 || in_tvalid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic conv_req_t rand_req();
    conv_req_t r;
    logic [63:0] tot;
    r.op = 1'($urandom_range(0, 1));
    tot = 1;
    for (int i = 0; i < 4; i++) tot *= (radix_q[i] == 0) ? 64'd1 : 64'(radix_q[i]);
    case ($urandom_range(0, 3))
      0: r.idx = $urandom();
      default: r.idx = (tot > 64'hFFFFFFFF) ? $urandom() : 32'(64'($urandom()) % (tot + 1));
    endcase
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 4) == 0) r.dig[i] = 8'($urandom_range(0, 255));
      else r.dig[i] = (radix_q[i] <= 1) ? 8'd0 : 8'($urandom_range(0, radix_q[i] - 1));
    end
    return r;
  endfunction

  initial begin
    logic [7:0] sets [6][4];
    conv_req_t r;
    rst_n = 0;
    cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    for (int i = 0; i < 4; i++) radix_q[i] = 2;
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // directed, at reset radices
    queue_req('{mrc_pkg::OP_SPLIT, 32'd0, '0});
    queue_req('{mrc_pkg::OP_SPLIT, 32'd15, '0});
    queue_req('{mrc_pkg::OP_SPLIT, 32'd16, '0});
    queue_req('{mrc_pkg::OP_SPLIT, 32'hFFFFFFFF, '0});
    queue_req('{mrc_pkg::OP_COMBINE, 32'd0, {8'd1, 8'd1, 8'd1, 8'd1}});
    queue_req('{mrc_pkg::OP_COMBINE, 32'hFFFFFFFF, {8'd254, 8'd0, 8'd2, 8'd0}});
    drain_pipe();

    // radix sets: all zero, all 255, then mixed values
    sets[0] = '{8'd0, 8'd0, 8'd0, 8'd0};
    sets[1] = '{8'd255, 8'd255, 8'd255, 8'd255};
    sets[2] = '{8'd1, 8'd255, 8'd0, 8'd7};
    sets[3] = '{8'd10, 8'd10, 8'd10, 8'd10};
    sets[4] = '{8'd3, 8'd200, 8'd1, 8'd17};
    sets[5] = '{8'd255, 8'd2, 8'd255, 8'd1};
    for (int s = 0; s < 6; s++) begin
      for (int i = 0; i < 4; i++) write_radix(i[1:0], sets[s][i]);
      if (s < 2) begin
        queue_req('{mrc_pkg::OP_SPLIT, 32'hFFFFFFFF, '0});
        queue_req('{mrc_pkg::OP_SPLIT, 32'hFC05FC00, '0});
        queue_req('{mrc_pkg::OP_SPLIT, 32'hFC05FC01, '0});
        queue_req('{mrc_pkg::OP_COMBINE, 32'd0, {8'd254, 8'd254, 8'd254, 8'd254}});
        queue_req('{mrc_pkg::OP_COMBINE, 32'd0, {8'd0, 8'd0, 8'd0, 8'd0}});
      end
      if (s == 3) hold_req = 1;  // fill the pipe and stall the input
      for (int n = 0; n < 100; n++) begin
        r = rand_req();
        queue_req(r);
      end
      drain_pipe();
    end

    if (errors == 0) $display("tb_mixed_radix_index_convert_top: done, clean");
    else $display("tb_mixed_radix_index_convert_top: done, errors");
    $finish;
  end

endmodule
